@@ src/assert_macros.svh @@
// assertion helper macros for the rtl files, used by load_classification_table
// expects clk and rst_n to be visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define LCT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/lct_pkg.sv @@
// shared types and constants for the load classification table
// no dependencies
package lct_pkg;

    // default sizing
    localparam int MAX_ENTRIES_DEF   = 2048;
    localparam int COUNTER_WIDTH_DEF = 4;

    // configuration register widths
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_INDEX_W = 2;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COUNTER_BITS  = 2'd0,
        REG_PRED_THRESH   = 2'd1,
        REG_CONST_THRESH  = 2'd2,
        REG_INDEX_BITS    = 2'd3
    } cfg_reg_t;

    // request codes
    typedef enum logic {
        REQ_CLASSIFY = 1'b0,
        REQ_UPDATE   = 1'b1
    } req_t;

    // class codes
    typedef enum logic [1:0] {
        CLASS_UNPREDICTABLE = 2'd0,
        CLASS_PREDICTABLE   = 2'd1,
        CLASS_CONSTANT      = 2'd2
    } load_class_t;

    // threshold value that turns a class off
    localparam logic signed [4:0] THRESH_DISABLE = -5'sd1;

    // register reset values
    localparam logic [2:0]        COUNTER_BITS_RST = 3'd2;
    localparam logic signed [4:0] PRED_THRESH_RST  = 5'sd2;
    localparam logic signed [4:0] CONST_THRESH_RST = 5'sd3;
    localparam logic [3:0]        INDEX_BITS_RST   = 4'd8;

    // configuration seen by the datapath
    typedef struct packed {
        logic [2:0]        counter_bits;
        logic signed [4:0] predictable_threshold;
        logic signed [4:0] constant_threshold;
        logic [3:0]        index_bits;
    } cfg_t;

endpackage

@@ src/lct_cfg.sv @@
// configuration register file for the load classification table
// depends on lct_pkg
module lct_cfg
    import lct_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.counter_bits          <= COUNTER_BITS_RST;
            cfg_reg.predictable_threshold <= PRED_THRESH_RST;
            cfg_reg.constant_threshold    <= CONST_THRESH_RST;
            cfg_reg.index_bits            <= INDEX_BITS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COUNTER_BITS: cfg_reg.counter_bits          <= cfg_data[2:0];
                REG_PRED_THRESH:  cfg_reg.predictable_threshold <= $signed(cfg_data);
                REG_CONST_THRESH: cfg_reg.constant_threshold    <= $signed(cfg_data);
                REG_INDEX_BITS:   cfg_reg.index_bits            <= cfg_data[3:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/lct_ram.sv @@
// counter storage: one write port, one read port with registered read data
// no dependencies
module lct_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 4,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/lct_eval.sv @@
// classification and saturating update of one confidence counter
// depends on lct_pkg
module lct_eval
    import lct_pkg::*;
#(
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
    input  cfg_t                     cfg,
    input  logic [COUNTER_WIDTH-1:0] cur_val,
    input  logic                     pred_correct,
    output logic [1:0]               load_class,
    output logic [COUNTER_WIDTH-1:0] new_val
);

    logic [3:0]               width_eff;
    logic [COUNTER_WIDTH-1:0] max_val;
    logic [COUNTER_WIDTH-1:0] masked;
    logic                     meets_const;
    logic                     meets_pred;

    // effective counter width, clamped to 1..COUNTER_WIDTH
    always_comb
    begin
        width_eff = {1'b0, cfg.counter_bits};
        if (width_eff == 4'd0)
        begin
            width_eff = 4'd1;
        end
        if (width_eff > 4'(COUNTER_WIDTH))
        begin
            width_eff = 4'(COUNTER_WIDTH);
        end
    end

    // saturation value as a low-bit mask
    always_comb
    begin
        for (int j = 0; j < COUNTER_WIDTH; j++)
        begin
            max_val[j] = (int'(width_eff) > j);
        end
    end

    // threshold compares, constant wins over predictable
    assign masked      = cur_val & max_val;
    assign meets_const = (cfg.constant_threshold != THRESH_DISABLE)
                         && (int'(masked) >= int'(cfg.constant_threshold));
    assign meets_pred  = (cfg.predictable_threshold != THRESH_DISABLE)
                         && (int'(masked) >= int'(cfg.predictable_threshold));

    always_comb
    begin
        if (meets_const)
        begin
            load_class = CLASS_CONSTANT;
        end
        else if (meets_pred)
        begin
            load_class = CLASS_PREDICTABLE;
        end
        else
        begin
            load_class = CLASS_UNPREDICTABLE;
        end
    end

    // saturating step; a stored value above max holds on a correct outcome
    always_comb
    begin
        new_val = cur_val;
        if (pred_correct)
        begin
            if (cur_val < max_val)
            begin
                new_val = cur_val + COUNTER_WIDTH'(1);
            end
        end
        else if (cur_val != '0)
        begin
            new_val = cur_val - COUNTER_WIDTH'(1);
        end
    end

endmodule

@@ src/load_classification_table.sv @@
// Load classification table: one request per cycle while busy is low,
// two-stage pipeline: stage-one registers, then the result registers for
// done and load_class. Throughput: one request per clock while busy is low,
// set by the single read and write ports of the counter memory; updates
// forward to the next read. Reset: config and control registers reset and a
// clearing pass zeroes all MAX_ENTRIES counters, one per cycle, while busy.
`include "assert_macros.svh"

module load_classification_table
    import lct_pkg::*;
#(
    parameter int MAX_ENTRIES   = MAX_ENTRIES_DEF,
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   req_type,
    input  logic [63:0]            load_pc,
    input  logic                   pred_correct,
    output logic                   done,
    output logic [1:0]             load_class,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);

    cfg_t                     cfg;
    logic                     accept;
    logic                     classify_in;
    logic [IDX_W-1:0]         idx_mask;
    logic [IDX_W-1:0]         idx_in;

    logic                     clearing_reg;
    logic [IDX_W-1:0]         clr_idx_reg;

    logic                     s1_valid_reg;
    logic                     s1_type_reg;
    logic                     s1_correct_reg;
    logic [IDX_W-1:0]         s1_idx_reg;
    logic                     s1_classify;

    logic                     byp_hit_reg;
    logic [COUNTER_WIDTH-1:0] byp_data_reg;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_wr_addr;
    logic [COUNTER_WIDTH-1:0] ram_wr_data;
    logic [COUNTER_WIDTH-1:0] ram_rd_data;

    logic [COUNTER_WIDTH-1:0] cur_val;
    logic [COUNTER_WIDTH-1:0] new_val;
    logic [1:0]               class_comb;

    logic                     done_reg;
    logic [1:0]               load_class_reg;

    // configuration registers
    lct_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // request transfer
    assign busy        = clearing_reg;
    assign accept      = start && !busy;
    assign classify_in = accept && (req_type == REQ_CLASSIFY);

    // table index from the low pc bits
    always_comb
    begin
        for (int i = 0; i < IDX_W; i++)
        begin
            idx_mask[i] = (int'(cfg.index_bits) > i);
        end
    end
    assign idx_in = load_pc[IDX_W-1:0] & idx_mask;

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            if (clr_idx_reg == '1)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // stage one: request held while the counter is read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_hit_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            byp_hit_reg  <= accept && ram_we && (ram_wr_addr == idx_in);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_type_reg    <= req_type;
            s1_correct_reg <= pred_correct;
            s1_idx_reg     <= idx_in;
        end
        byp_data_reg <= ram_wr_data;
    end

    assign s1_classify = s1_valid_reg && (s1_type_reg == REQ_CLASSIFY);

    // write port: clearing pass or update write-back
    assign ram_we      = clearing_reg || (s1_valid_reg && (s1_type_reg == REQ_UPDATE));
    assign ram_wr_addr = clearing_reg ? clr_idx_reg : s1_idx_reg;
    assign ram_wr_data = clearing_reg ? '0 : new_val;

    lct_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (COUNTER_WIDTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (idx_in),
        .rd_data (ram_rd_data)
    );

    // counter value with the previous write forwarded
    assign cur_val = byp_hit_reg ? byp_data_reg : ram_rd_data;

    lct_eval #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_eval (
        .cfg          (cfg),
        .cur_val      (cur_val),
        .pred_correct (s1_correct_reg),
        .load_class   (class_comb),
        .new_val      (new_val)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s1_classify;
        end
    end

    always_ff @(posedge clk)
    begin
        load_class_reg <= class_comb;
    end

    assign done       = done_reg;
    assign load_class = load_class_reg;

    // checks
    `LCT_ASSERT_NEXT(a_classify_done, classify_in, ##1 done, "classify transfer gave no result")
    `LCT_ASSERT_SAME(a_done_source, done, $past(s1_classify), "result with no classify request")
    `LCT_ASSERT_SAME(a_no_result_clear, clearing_reg, !done, "result during clearing pass")
    `LCT_ASSERT_SAME(a_class_code, done, load_class <= CLASS_CONSTANT, "unused class code")

endmodule
